// ===== sv/segment_box_crossing_test_defines.svh =====
// Assertion macros for the segment box crossing test.
`ifndef SEGMENT_BOX_CROSSING_TEST_DEFINES_SVH
`define SEGMENT_BOX_CROSSING_TEST_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define SBCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define SBCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sbct_pkg.sv =====
// Package: constants, types and functions of the segment box crossing test.
`timescale 1ns / 1ps
package sbct_pkg;

    localparam int STRETCH_FACTOR_DEF = 10001;
    localparam int COORD_WIDTH_DEF    = 32;
    localparam int NEAR_TOL           = 65;
    localparam int NUM_STAGES         = 5;

    localparam logic [31:0] BOX_LEFT_RST   = 32'd0;
    localparam logic [31:0] BOX_BOTTOM_RST = 32'd0;
    localparam logic [30:0] BOX_WIDTH_RST  = 31'd131072;
    localparam logic [30:0] BOX_HEIGHT_RST = 31'd65536;

    typedef enum logic [1:0] {
        REG_BOX_LEFT   = 2'd0,
        REG_BOX_BOTTOM = 2'd1,
        REG_BOX_WIDTH  = 2'd2,
        REG_BOX_HEIGHT = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } t_dir;

    // hits in side order left, top, right, bottom; adjacent pairs cancel one
    function automatic logic [2:0] f_count(input logic [3:0] hit);
        logic [2:0] n;
        logic [2:0] adj;
        begin
            n   = 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]);
            adj = 3'(hit[0] & hit[1]) + 3'(hit[1] & hit[2])
                + 3'(hit[2] & hit[3]) + 3'(hit[3] & hit[0]);
            f_count = n - adj;
        end
    endfunction

endpackage

// ===== sv/segment_box_crossing_test.sv =====
// Top level: pipelined segment versus box crossing test with APB register port.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  input   | in        | i_valid / o_stall  | i_start_x, i_start_y, i_end_x, i_end_y
//  output  | out       | o_valid / i_stall  | o_crosses, o_plain_count, o_high/low counts
//  config  | in        | psel/penable/...   | box_left, box_bottom, box_width, box_height
//
// Five register stages: differences, abs and direction, products, compares, counts.
// One word per cycle in while o_stall is low; the product stage sets the cycle time.
// Each stage advances when empty or when the stage after it advances.
// Reset clears valid bits and loads the box registers with their defaults.
`timescale 1ns / 1ps
`include "segment_box_crossing_test_defines.svh"
module segment_box_crossing_test #(
    parameter int STRETCH_FACTOR = sbct_pkg::STRETCH_FACTOR_DEF,
    parameter int COORD_WIDTH    = sbct_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [COORD_WIDTH-1:0]  i_start_x,
    input  logic signed [COORD_WIDTH-1:0]  i_start_y,
    input  logic signed [COORD_WIDTH-1:0]  i_end_x,
    input  logic signed [COORD_WIDTH-1:0]  i_end_y,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_crosses,
    output logic [2:0]                     o_plain_count,
    output logic [2:0]                     o_high_stretch_count,
    output logic [2:0]                     o_low_stretch_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int DW = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 2;
    localparam int PW = 2 * DW;
    localparam int NS = sbct_pkg::NUM_STAGES;
    localparam logic signed [PW-1:0] STRETCH_M1 = PW'(STRETCH_FACTOR - 1);
    localparam logic signed [DW-1:0] NEAR_TOL_D = DW'(sbct_pkg::NEAR_TOL);

    logic signed [31:0] r_box_left;
    logic signed [31:0] r_box_bottom;
    logic [30:0]        r_box_width;
    logic [30:0]        r_box_height;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    logic signed [DW-1:0] r_s1_d  [2];
    logic signed [DW-1:0] r_s1_lo [2];
    logic signed [DW-1:0] r_s1_hi [2];
    logic signed [DW-1:0] n_s1_d  [2];
    logic signed [DW-1:0] n_s1_lo [2];
    logic signed [DW-1:0] n_s1_hi [2];

    logic signed [DW-1:0] r_s2_d  [2];
    logic signed [DW-1:0] r_s2_m  [2];
    logic signed [DW-1:0] r_s2_lo [2];
    logic signed [DW-1:0] r_s2_hi [2];
    logic signed [DW-1:0] r_s2_n  [4];
    sbct_pkg::t_dir       r_s2_dir;
    logic signed [DW-1:0] n_s2_m  [2];
    logic signed [DW-1:0] n_s2_n  [4];
    sbct_pkg::t_dir       n_s2_dir;

    logic signed [DW-1:0] r_s3_n    [4];
    logic signed [PW-1:0] r_s3_prod [4];
    logic signed [DW-1:0] r_s3_m    [2];
    logic signed [PW-1:0] r_s3_ulo  [2];
    logic signed [PW-1:0] r_s3_uhi  [2];
    logic signed [PW-1:0] r_s3_p    [2];
    sbct_pkg::t_dir       r_s3_dir;

    logic [3:0] r_s4_hp, r_s4_hh, r_s4_hl;
    logic [3:0] n_s4_hp, n_s4_hh, n_s4_hl;

    logic       r_s5_crosses;
    logic [2:0] r_s5_pc, r_s5_hc, r_s5_lc;

    logic cfg_wr;
    logic verdict_ok;
    logic counts_ok;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left   <= sbct_pkg::BOX_LEFT_RST;
            r_box_bottom <= sbct_pkg::BOX_BOTTOM_RST;
            r_box_width  <= sbct_pkg::BOX_WIDTH_RST;
            r_box_height <= sbct_pkg::BOX_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (sbct_pkg::t_reg_idx'(paddr[3:2]))
                sbct_pkg::REG_BOX_LEFT:   r_box_left   <= pwdata;
                sbct_pkg::REG_BOX_BOTTOM: r_box_bottom <= pwdata;
                sbct_pkg::REG_BOX_WIDTH:  r_box_width  <= pwdata[30:0];
                sbct_pkg::REG_BOX_HEIGHT: r_box_height <= pwdata[30:0];
            endcase
        end
    end

    always_comb begin
        unique case (sbct_pkg::t_reg_idx'(paddr[3:2]))
            sbct_pkg::REG_BOX_LEFT:   prdata = r_box_left;
            sbct_pkg::REG_BOX_BOTTOM: prdata = r_box_bottom;
            sbct_pkg::REG_BOX_WIDTH:  prdata = {1'b0, r_box_width};
            sbct_pkg::REG_BOX_HEIGHT: prdata = {1'b0, r_box_height};
        endcase
    end

    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end
    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: segment vector and box offsets from end 1
    always_comb begin
        n_s1_d[0]  = DW'(i_end_x) - DW'(i_start_x);
        n_s1_d[1]  = DW'(i_end_y) - DW'(i_start_y);
        n_s1_lo[0] = DW'(r_box_bottom) - DW'(i_start_y);
        n_s1_lo[1] = DW'(r_box_left) - DW'(i_start_x);
        n_s1_hi[0] = n_s1_lo[0] + $signed(DW'(r_box_height));
        n_s1_hi[1] = n_s1_lo[1] + $signed(DW'(r_box_width));
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_d  <= n_s1_d;
            r_s1_lo <= n_s1_lo;
            r_s1_hi <= n_s1_hi;
        end
    end

    // stage 2: magnitudes, side numerators in sign-normalized form, direction
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_s2_m[a] = r_s1_d[a][DW-1] ? -r_s1_d[a] : r_s1_d[a];
        end
        n_s2_n[0] = r_s1_d[0][DW-1] ? -r_s1_lo[1] : r_s1_lo[1];
        n_s2_n[1] = r_s1_d[1][DW-1] ? -r_s1_hi[0] : r_s1_hi[0];
        n_s2_n[2] = r_s1_d[0][DW-1] ? -r_s1_hi[1] : r_s1_hi[1];
        n_s2_n[3] = r_s1_d[1][DW-1] ? -r_s1_lo[0] : r_s1_lo[0];
        priority if (n_s2_m[0] > NEAR_TOL_D) begin
            n_s2_dir = r_s1_d[0][DW-1] ? sbct_pkg::DIR_NEG : sbct_pkg::DIR_POS;
        end else if (n_s2_m[1] > NEAR_TOL_D) begin
            n_s2_dir = r_s1_d[1][DW-1] ? sbct_pkg::DIR_NEG : sbct_pkg::DIR_POS;
        end else begin
            n_s2_dir = sbct_pkg::DIR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s2_d   <= r_s1_d;
            r_s2_m   <= n_s2_m;
            r_s2_lo  <= r_s1_lo;
            r_s2_hi  <= r_s1_hi;
            r_s2_n   <= n_s2_n;
            r_s2_dir <= n_s2_dir;
        end
    end

    // stage 3: products
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int j = 0; j < 4; j++) begin
                r_s3_prod[j] <= PW'(r_s2_n[j]) * PW'(r_s2_d[(j % 2 == 0) ? 1 : 0]);
            end
            for (int a = 0; a < 2; a++) begin
                r_s3_ulo[a] <= PW'(r_s2_lo[a]) * PW'(r_s2_m[a]);
                r_s3_uhi[a] <= PW'(r_s2_hi[a]) * PW'(r_s2_m[a]);
                r_s3_p[a]   <= STRETCH_M1 * PW'(r_s2_m[a]);
            end
            r_s3_n   <= r_s2_n;
            r_s3_m   <= r_s2_m;
            r_s3_dir <= r_s2_dir;
        end
    end

    // stage 4: range compares per side and test
    always_comb begin
        logic                 side_ok;
        logic                 t_ge0, t_geneg, t_le1, t_les;
        logic signed [PW-1:0] nw, mw;
        logic [3:0]           h_plain, h_end2, h_end1;
        h_plain = '0;
        h_end2  = '0;
        h_end1  = '0;
        for (int j = 0; j < 4; j++) begin
            nw      = PW'(r_s3_n[j]);
            mw      = PW'(r_s3_m[j % 2]);
            side_ok = (r_s3_m[j % 2] != '0)
                   && ((j % 2 == 0) ? (r_box_height != '0) : (r_box_width != '0))
                   && (r_s3_prod[j] >= r_s3_ulo[j % 2])
                   && (r_s3_prod[j] <= r_s3_uhi[j % 2]);
            t_ge0   = !r_s3_n[j][DW-1];
            t_geneg = nw >= -r_s3_p[j % 2];
            t_le1   = nw <= mw;
            t_les   = nw <= r_s3_p[j % 2] + mw;
            h_plain[j] = side_ok && t_ge0 && t_le1;
            h_end2[j]  = side_ok && t_ge0 && t_les;
            h_end1[j]  = side_ok && t_geneg && t_le1;
        end
        n_s4_hp = h_plain;
        unique case (r_s3_dir)
            sbct_pkg::DIR_POS: begin
                n_s4_hh = h_end2;
                n_s4_hl = h_end1;
            end
            sbct_pkg::DIR_NEG: begin
                n_s4_hh = h_end1;
                n_s4_hl = h_end2;
            end
            default: begin
                n_s4_hh = h_plain;
                n_s4_hl = h_plain;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s4_hp <= n_s4_hp;
            r_s4_hh <= n_s4_hh;
            r_s4_hl <= n_s4_hl;
        end
    end

    // stage 5: counts and verdict
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s5_pc      <= sbct_pkg::f_count(r_s4_hp);
            r_s5_hc      <= sbct_pkg::f_count(r_s4_hh);
            r_s5_lc      <= sbct_pkg::f_count(r_s4_hl);
            r_s5_crosses <= (sbct_pkg::f_count(r_s4_hp) != '0)
                         || ((sbct_pkg::f_count(r_s4_hh) != '0)
                             && (sbct_pkg::f_count(r_s4_hl) != '0));
        end
    end

    assign o_valid              = r_v[NS-1];
    assign o_crosses            = r_s5_crosses;
    assign o_plain_count        = r_s5_pc;
    assign o_high_stretch_count = r_s5_hc;
    assign o_low_stretch_count  = r_s5_lc;

    assign verdict_ok = o_crosses == ((o_plain_count != 3'd0)
                     || ((o_high_stretch_count != 3'd0) && (o_low_stretch_count != 3'd0)));
    assign counts_ok  = (o_plain_count <= 3'd2) && (o_high_stretch_count <= 3'd2)
                     && (o_low_stretch_count <= 3'd2);

    `SBCT_ASSERT_NOW(a_verdict, o_valid, verdict_ok, "verdict disagrees with counts")
    `SBCT_ASSERT_NOW(a_count_max, o_valid, counts_ok, "count above two")
    `SBCT_ASSERT_NOW(a_empty_no_stall, !r_v[0], !o_stall, "stall with empty entry stage")
    `SBCT_ASSERT_NEXT(a_hold_out, o_valid && i_stall, o_valid, "stalled word lost")

endmodule

// ===== tb/segment_box_crossing_test_tb.sv =====
// Self-checking testbench for the segment versus box crossing test, scoreboard included.
`timescale 1ns / 1ps
module segment_box_crossing_test_tb;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic       crosses;
        logic [2:0] plain;
        logic [2:0] high;
        logic [2:0] low;
    } t_verdict;

    class crossing_board;
        t_verdict           pending[$];
        logic signed [31:0] left   = sbct_pkg::BOX_LEFT_RST;
        logic signed [31:0] bottom = sbct_pkg::BOX_BOTTOM_RST;
        logic [30:0]        width  = sbct_pkg::BOX_WIDTH_RST;
        logic [30:0]        height = sbct_pkg::BOX_HEIGHT_RST;
        int                 errors = 0;
        int                 words_in = 0;
        int                 crossings = 0;

        function automatic logic [2:0] side_hits(t_wide x1, t_wide y1, t_wide dx, t_wide dy,
                                                 t_wide lo_neg, t_wide hi);
            t_wide qx[4], qy[4], ex[4], ey[4];
            t_wide ox, oy, d, a, bb, l, b, w, h;
            logic [3:0] hit;
            int n;
            l = left; b = bottom; w = width; h = height;
            qx[0] = l;     qy[0] = b;     ex[0] = 0;  ey[0] = h;
            qx[1] = l;     qy[1] = b + h; ex[1] = w;  ey[1] = 0;
            qx[2] = l + w; qy[2] = b + h; ex[2] = 0;  ey[2] = -h;
            qx[3] = l + w; qy[3] = b;     ex[3] = -w; ey[3] = 0;
            hit = 4'b0;
            for (int j = 0; j < 4; j++) begin
                ox = qx[j] - x1;
                oy = qy[j] - y1;
                d  = dx * ey[j] - dy * ex[j];
                a  = ox * ey[j] - oy * ex[j];
                bb = ox * dy - oy * dx;
                if (d != 0) begin
                    if (d < 0) begin
                        d = -d; a = -a; bb = -bb;
                    end
                    if (bb >= 0 && bb <= d && a + d * lo_neg >= 0 && a <= d * hi)
                        hit[j] = 1'b1;
                end
            end
            n = hit[0] + hit[1] + hit[2] + hit[3];
            if (n == 0) return 3'd0;
            if (hit[0] && hit[3]) n--;
            for (int j = 1; j < 4; j++)
                if (hit[j-1] && hit[j]) n--;
            return (n < 0) ? 3'd0 : 3'(n);
        endfunction

        function void note_segment(logic signed [31:0] sx, logic signed [31:0] sy,
                                   logic signed [31:0] ex, logic signed [31:0] ey);
            t_wide x1, y1, dx, dy, adx, ady, s;
            t_wide hl, hh, ll, lh;
            sbct_pkg::t_dir dir;
            t_verdict v;
            x1 = sx; y1 = sy;
            dx = t_wide'(ex) - x1;
            dy = t_wide'(ey) - y1;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            s = sbct_pkg::STRETCH_FACTOR_DEF;
            hl = 0; hh = 1; ll = 0; lh = 1;
            dir = sbct_pkg::DIR_NONE;
            if (adx > sbct_pkg::NEAR_TOL)
                dir = dx > 0 ? sbct_pkg::DIR_POS : sbct_pkg::DIR_NEG;
            else if (ady > sbct_pkg::NEAR_TOL)
                dir = dy > 0 ? sbct_pkg::DIR_POS : sbct_pkg::DIR_NEG;
            if (dir == sbct_pkg::DIR_POS) begin
                hh = s; ll = s - 1;
            end else if (dir == sbct_pkg::DIR_NEG) begin
                hl = s - 1; lh = s;
            end
            v.plain = side_hits(x1, y1, dx, dy, 0, 1);
            v.high  = side_hits(x1, y1, dx, dy, hl, hh);
            v.low   = side_hits(x1, y1, dx, dy, ll, lh);
            v.crosses = (v.plain >= 1) || (v.high > 0 && v.low > 0);
            pending = {pending, v};
            words_in++;
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.crosses) crossings++;
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: crosses %b/%b plain %0d/%0d high %0d/%0d low %0d/%0d",
                             want.crosses, got.crosses, want.plain, got.plain,
                             want.high, got.high, want.low, got.low);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic signed [31:0] i_start_x = 0, i_start_y = 0, i_end_x = 0, i_end_y = 0;
    logic o_valid;
    logic i_stall = 0;
    logic o_crosses;
    logic [2:0] o_plain_count, o_high_stretch_count, o_low_stretch_count;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;

    crossing_board board = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req = 0;
    int box_settings = 1;

    segment_box_crossing_test dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL segment_box_crossing_test");
        $finish;
    end

    // receiver: random stall, long hold-off on request
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold == 0) hold = 300;
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
                if (hold == 0) hold_req = 0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_verdict({o_crosses, o_plain_count,
                                 o_high_stretch_count, o_low_stretch_count});
    end

    task automatic send_segment(logic [31:0] sx, logic [31:0] sy,
                                logic [31:0] ex, logic [31:0] ey);
        bit taken;
        i_valid   <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x   <= ex;
        i_end_y   <= ey;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        board.note_segment(sx, sy, ex, ey);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (sbct_pkg::NUM_STAGES + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(sbct_pkg::t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 4'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sbct_pkg::REG_BOX_LEFT:   board.left   = val;
            sbct_pkg::REG_BOX_BOTTOM: board.bottom = val;
            sbct_pkg::REG_BOX_WIDTH:  board.width  = val[30:0];
            sbct_pkg::REG_BOX_HEIGHT: board.height = val[30:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_box(logic [31:0] l, logic [31:0] b, logic [31:0] w, logic [31:0] h);
        drain();
        write_reg(sbct_pkg::REG_BOX_LEFT, l);
        write_reg(sbct_pkg::REG_BOX_BOTTOM, b);
        write_reg(sbct_pkg::REG_BOX_WIDTH, w);
        write_reg(sbct_pkg::REG_BOX_HEIGHT, h);
        box_settings++;
    endtask

    function automatic logic [31:0] near_coord(logic signed [31:0] base, logic [30:0] span);
        logic signed [63:0] v;
        logic signed [63:0] sp;
        sp = (span > 31'd4194304) ? 64'sd4194304 : 64'(span);
        case ($urandom_range(0, 3))
            0: v = base + $signed(64'($urandom_range(0, 3))) * sp - sp;
            1: v = base + $signed(64'($urandom_range(0, 32'(sp) * 3))) - sp;
            default: v = base + $signed(64'($urandom_range(0, 32'(sp) * 3))) - sp
                         + $signed(64'($urandom_range(0, 64))) - 32;
        endcase
        return v[31:0];
    endfunction

    task automatic random_segments(int count);
        logic [31:0] c[4];
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 20) begin
                foreach (c[i]) c[i] = $urandom;
            end else begin
                c[0] = near_coord(board.left, board.width);
                c[1] = near_coord(board.bottom, board.height);
                c[2] = near_coord(board.left, board.width);
                c[3] = near_coord(board.bottom, board.height);
                case ($urandom_range(0, 7))
                    0: c[2] = c[0] + $urandom_range(0, 130) - 65;
                    1: c[3] = c[1] + $urandom_range(0, 130) - 65;
                    2: begin
                        c[2] = c[0]; c[3] = c[1];
                    end
                    default: ;
                endcase
            end
            send_segment(c[0], c[1], c[2], c[3]);
            if (k == count / 3) hold_req = 1;
            if (k == count / 2) drain();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 29;
        rx_idle_pct = 49;
        send_segment(-32'sd65536, 32'sd32768, 32'sd196608, 32'sd32768);
        send_segment(32'sd196608, 32'sd32768, -32'sd65536, 32'sd32768);
        send_segment(32'sd65536, -32'sd65536, 32'sd65536, 32'sd131072);
        send_segment(32'sd65536, 32'sd131072, 32'sd65536, -32'sd65536);
        send_segment(32'sd65536, 32'sd32768, 32'sd65536, 32'sd32768);
        send_segment(32'sd0, 32'sd0, 32'sd131072, 32'sd0);
        send_segment(-32'sd65536, -32'sd65536, 32'sd196608, 32'sd131072);
        send_segment(-32'sd131072, -32'sd65536, 32'sd262144, 32'sd131072);
        send_segment(32'sd65536, 32'sd32768, 32'sd65602, 32'sd32768);
        send_segment(32'sd65536, 32'sd32768, 32'sd65601, 32'sd32768);
        send_segment(32'sd65536, 32'sd32768, 32'sd65536, 32'sd32834);
        send_segment(32'sd65536, 32'sd32768, 32'sd65536, 32'sd32702);
        send_segment(32'sd262144, 32'sd32768, 32'sd327680, 32'sd32768);
        send_segment(32'sd327680, 32'sd32768, 32'sd262144, 32'sd32768);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_segment(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_segment(32'sd500000, 32'sd500000, 32'sd600000, 32'sd600000);
        send_segment(32'sd65536, 32'sd32768, 32'sd70000, 32'sd40000);
        send_segment(-32'sd65536, 32'sd0, 32'sd196608, 32'sd0);
        random_segments(500);

        set_box(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
        random_segments(150);
        set_box(32'hffff_0000, 32'hfffe_0000, 32'd1, 32'h7fff_ffff);
        random_segments(150);

        tx_idle_pct = 49;
        rx_idle_pct = 29;
        set_box(32'd100, 32'hffff_ff00, 32'd200, 32'd300);
        random_segments(300);
        set_box($urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                $urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                $urandom_range(1, 32'h0010_0000), $urandom_range(1, 32'h0010_0000));
        random_segments(300);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_box(32'd0, 32'd0, 32'd131072, 32'd65536);
        random_segments(300);
        set_box($urandom, $urandom, $urandom_range(1, 32'h7fff_ffff),
                $urandom_range(1, 32'h7fff_ffff));
        random_segments(300);

        drain();
        repeat (20) @(posedge i_clk);
        $display("ran %0d segments against %0d box settings, %0d judged crossing, %0d errors",
                 board.words_in, box_settings, board.crossings, board.errors);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS segment_box_crossing_test");
        end else begin
            $display("FAIL segment_box_crossing_test");
        end
        $finish;
    end
endmodule
